FILE: rtl/core/ordered_list_engine_defines.svh
// assertion helpers for the file that checks the engine
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// a condition that holds at every clock edge out of reset
`define OLE_ASSERT_HOLDS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ordered list engine: invariant broken");

// a condition that must hold in the cycle after its trigger
`define OLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list engine: sequence broken");

`endif

FILE: rtl/core/ole_pkg.sv
`timescale 1ns / 1ps

package ole_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 4;
    localparam int POS_W         = 5;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_BACK    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT_AT    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT    = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DELETE_AT    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DELETE_VALUE = 4'd6;
    localparam logic [MODE_W-1:0] MODE_UPDATE_AT    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_READ_AT      = 4'd8;
    localparam logic [MODE_W-1:0] MODE_READ_PREV    = 4'd9;
    localparam logic [MODE_W-1:0] MODE_READ_NEXT    = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } ole_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
    } ole_rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } cell_op_t;

    typedef enum logic [1:0] {
        TAP_HOLD,
        TAP_LOAD,
        TAP_SHIFT
    } tap_op_t;

    typedef struct packed {
        cell_op_t                 op;
        tap_op_t                  tap_op;
        logic signed [DATA_W-1:0] data;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SEARCH,
        S_DONE
    } ole_state_t;

endpackage

FILE: rtl/core/ole_cell.sv
`timescale 1ns / 1ps

module ole_cell #(
    parameter int INDEX = 0,
    parameter int AW    = 5
) (
    input  logic                               clk,
    input  ole_pkg::cell_cmd_t                 cmd,
    input  logic [AW-1:0]                      at,
    input  logic signed [ole_pkg::DATA_W-1:0]  prev_entry,
    input  logic signed [ole_pkg::DATA_W-1:0]  next_entry,
    input  logic signed [ole_pkg::DATA_W-1:0]  next_tap,
    output logic signed [ole_pkg::DATA_W-1:0]  entry,
    output logic signed [ole_pkg::DATA_W-1:0]  tap
);

    localparam logic [AW-1:0] MY_POS = AW'(INDEX);

    logic signed [ole_pkg::DATA_W-1:0] entry_reg;
    logic signed [ole_pkg::DATA_W-1:0] entry_next;
    logic signed [ole_pkg::DATA_W-1:0] tap_reg;
    logic signed [ole_pkg::DATA_W-1:0] tap_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            ole_pkg::CELL_INSERT:
            begin
                // open a gap: cells past the slot take their left neighbour
                if (MY_POS > at)
                begin
                    entry_next = prev_entry;
                end
                else if (MY_POS == at)
                begin
                    entry_next = cmd.data;
                end
            end
            ole_pkg::CELL_REMOVE:
            begin
                if (MY_POS >= at)
                begin
                    entry_next = next_entry;
                end
            end
            ole_pkg::CELL_WRITE:
            begin
                if (MY_POS == at)
                begin
                    entry_next = cmd.data;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.tap_op)
            ole_pkg::TAP_LOAD:  tap_next = entry_reg;
            ole_pkg::TAP_SHIFT: tap_next = next_tap;
            default:            tap_next = tap_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

FILE: rtl/core/ordered_list_engine.sv
`timescale 1ns / 1ps
`include "ordered_list_engine_defines.svh"

// Bounded ordered list of up to DEPTH signed 32-bit values, held in a row of
// cells, one entry per cell at its list position. Push, insert, pop, delete
// at a position and update act on every cell in parallel as the request is
// accepted; such a request then passes through S_DONE, where its response is
// registered once the response register is free, and back to S_IDLE before
// the next can be taken. Reads and delete by value walk a tap chain along the
// cells towards cell 0, one cell per cycle, in S_SCAN or S_SEARCH before
// S_DONE. One request is in flight at a time; the next is taken as soon as
// the previous response is registered, even if that response has not been
// collected yet. Failed requests change nothing.
module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ole_pkg::ole_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output ole_pkg::ole_rsp_t rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_INSERT,
        ACT_REMOVE,
        ACT_WRITE,
        ACT_READ,
        ACT_SEARCH
    } act_t;

    ole_pkg::ole_state_t state_reg;
    ole_pkg::ole_state_t state_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [AW-1:0]       cnt_reg;
    logic [AW-1:0]       cnt_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;

    logic signed [ole_pkg::DATA_W-1:0] val_reg;
    logic signed [ole_pkg::DATA_W-1:0] val_next;
    logic signed [ole_pkg::DATA_W-1:0] pend_rd_reg;
    logic signed [ole_pkg::DATA_W-1:0] pend_rd_next;
    logic [ole_pkg::STATUS_W-1:0]      pend_status_reg;
    logic [ole_pkg::STATUS_W-1:0]      pend_status_next;
    ole_pkg::ole_rsp_t                 rsp_reg;
    ole_pkg::ole_rsp_t                 rsp_next;

    logic                         accept;
    logic                         rsp_free;
    logic [AW-1:0]                n_ext;
    logic [AW-1:0]                p_ext;
    logic [AW-1:0]                ins_at;
    logic [ole_pkg::STATUS_W-1:0] d_status;
    act_t                         d_act;
    logic [AW-1:0]                d_at;

    ole_pkg::cell_cmd_t                cmd;
    logic [AW-1:0]                     cmd_at;
    logic signed [ole_pkg::DATA_W-1:0] entry_w [DEPTH];
    logic signed [ole_pkg::DATA_W-1:0] tap_w [DEPTH];
    logic signed [ole_pkg::DATA_W-1:0] tap0;

    assign req_ready = (state_reg == ole_pkg::S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign n_ext     = AW'(count_reg);
    assign p_ext     = AW'(req.position);
    assign tap0      = tap_w[0];

    // request decode: status checks against the current count
    always_comb
    begin
        d_status = ole_pkg::ST_OK;
        d_act    = ACT_NONE;
        d_at     = '0;
        ins_at   = p_ext;
        case (req.mode)
            ole_pkg::MODE_PUSH_BACK, ole_pkg::MODE_PUSH_FRONT, ole_pkg::MODE_INSERT_AT:
            begin
                if (req.mode == ole_pkg::MODE_PUSH_BACK)
                begin
                    ins_at = n_ext;
                end
                else if (req.mode == ole_pkg::MODE_PUSH_FRONT)
                begin
                    ins_at = '0;
                end
                if (ins_at > n_ext)
                begin
                    d_status = ole_pkg::ST_RANGE;
                end
                else if (n_ext >= AW'(DEPTH))
                begin
                    d_status = ole_pkg::ST_FULL;
                end
                else
                begin
                    d_act = ACT_INSERT;
                    d_at  = ins_at;
                end
            end
            ole_pkg::MODE_POP_BACK, ole_pkg::MODE_POP_FRONT:
            begin
                if (n_ext == '0)
                begin
                    d_status = ole_pkg::ST_EMPTY;
                end
                else
                begin
                    d_act = ACT_REMOVE;
                    d_at  = (req.mode == ole_pkg::MODE_POP_BACK) ? n_ext - AW'(1) : '0;
                end
            end
            ole_pkg::MODE_DELETE_AT, ole_pkg::MODE_UPDATE_AT, ole_pkg::MODE_READ_AT,
            ole_pkg::MODE_READ_PREV, ole_pkg::MODE_READ_NEXT:
            begin
                if (n_ext == '0)
                begin
                    d_status = ole_pkg::ST_EMPTY;
                end
                else if (p_ext >= n_ext)
                begin
                    d_status = ole_pkg::ST_RANGE;
                end
                else if (req.mode == ole_pkg::MODE_DELETE_AT)
                begin
                    d_act = ACT_REMOVE;
                    d_at  = p_ext;
                end
                else if (req.mode == ole_pkg::MODE_UPDATE_AT)
                begin
                    d_act = ACT_WRITE;
                    d_at  = p_ext;
                end
                else if (req.mode == ole_pkg::MODE_READ_AT)
                begin
                    d_act = ACT_READ;
                    d_at  = p_ext;
                end
                else if (req.mode == ole_pkg::MODE_READ_PREV)
                begin
                    if (p_ext == '0)
                    begin
                        d_status = ole_pkg::ST_RANGE;
                    end
                    else
                    begin
                        d_act = ACT_READ;
                        d_at  = p_ext - AW'(1);
                    end
                end
                else
                begin
                    if (p_ext + AW'(1) >= n_ext)
                    begin
                        d_status = ole_pkg::ST_RANGE;
                    end
                    else
                    begin
                        d_act = ACT_READ;
                        d_at  = p_ext + AW'(1);
                    end
                end
            end
            ole_pkg::MODE_DELETE_VALUE:
            begin
                if (n_ext == '0)
                begin
                    d_status = ole_pkg::ST_EMPTY;
                end
                else
                begin
                    d_act = ACT_SEARCH;
                end
            end
            default:
            begin
                d_status = ole_pkg::ST_RANGE;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (d_act == ACT_READ)
                    begin
                        state_next = ole_pkg::S_SCAN;
                    end
                    else if (d_act == ACT_SEARCH)
                    begin
                        state_next = ole_pkg::S_SEARCH;
                    end
                    else
                    begin
                        state_next = ole_pkg::S_DONE;
                    end
                end
            end
            ole_pkg::S_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ole_pkg::S_DONE;
                end
            end
            ole_pkg::S_SEARCH:
            begin
                if (cnt_reg == n_ext || tap0 == val_reg)
                begin
                    state_next = ole_pkg::S_DONE;
                end
            end
            ole_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    // cell commands and datapath
    always_comb
    begin
        cmd.op           = ole_pkg::CELL_HOLD;
        cmd.tap_op       = ole_pkg::TAP_HOLD;
        cmd.data         = req.value;
        cmd_at           = d_at;
        count_next       = count_reg;
        cnt_next         = cnt_reg;
        val_next         = val_reg;
        pend_rd_next     = pend_rd_reg;
        pend_status_next = pend_status_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    val_next         = req.value;
                    pend_rd_next     = '0;
                    pend_status_next = d_status;
                    case (d_act)
                        ACT_INSERT:
                        begin
                            cmd.op     = ole_pkg::CELL_INSERT;
                            count_next = count_reg + CW'(1);
                        end
                        ACT_REMOVE:
                        begin
                            cmd.op     = ole_pkg::CELL_REMOVE;
                            count_next = count_reg - CW'(1);
                        end
                        ACT_WRITE:
                        begin
                            cmd.op = ole_pkg::CELL_WRITE;
                        end
                        ACT_READ:
                        begin
                            cmd.tap_op = ole_pkg::TAP_LOAD;
                            cnt_next   = d_at;
                        end
                        ACT_SEARCH:
                        begin
                            cmd.tap_op = ole_pkg::TAP_LOAD;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            cmd.op = ole_pkg::CELL_HOLD;
                        end
                    endcase
                end
            end
            ole_pkg::S_SCAN:
            begin
                // taps slide towards cell 0 until the target sits there
                if (cnt_reg == '0)
                begin
                    pend_rd_next = tap0;
                end
                else
                begin
                    cmd.tap_op = ole_pkg::TAP_SHIFT;
                    cnt_next   = cnt_reg - AW'(1);
                end
            end
            ole_pkg::S_SEARCH:
            begin
                cmd_at = cnt_reg;
                if (cnt_reg == n_ext)
                begin
                    pend_status_next = ole_pkg::ST_NOTFOUND;
                end
                else if (tap0 == val_reg)
                begin
                    cmd.op     = ole_pkg::CELL_REMOVE;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    cmd.tap_op = ole_pkg::TAP_SHIFT;
                    cnt_next   = cnt_reg + AW'(1);
                end
            end
            ole_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.read_value = pend_rd_reg;
                    rsp_next.status     = pend_status_reg;
                    rsp_next.count      = ole_pkg::COUNT_W'(count_reg);
                    rsp_valid_next      = 1'b1;
                end
            end
            default:
            begin
                cmd.op = ole_pkg::CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ole_pkg::S_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg         <= val_next;
        pend_rd_reg     <= pend_rd_next;
        pend_status_reg <= pend_status_next;
        rsp_reg         <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [ole_pkg::DATA_W-1:0] prev_e;
        logic signed [ole_pkg::DATA_W-1:0] next_e;
        logic signed [ole_pkg::DATA_W-1:0] next_t;

        if (i == 0)
        begin : g_first
            assign prev_e = '0;
        end
        else
        begin : g_mid_prev
            assign prev_e = entry_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_e = '0;
            assign next_t = '0;
        end
        else
        begin : g_mid_next
            assign next_e = entry_w[i+1];
            assign next_t = tap_w[i+1];
        end

        ole_cell #(
            .INDEX (i),
            .AW    (AW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .at         (cmd_at),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .next_tap   (next_t),
            .entry      (entry_w[i]),
            .tap        (tap_w[i])
        );
    end

    `OLE_ASSERT_HOLDS(a_count_bound, count_reg <= CW'(DEPTH))
    `OLE_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_reg != ole_pkg::S_IDLE)
    `OLE_ASSERT_NEXT(a_idle_count, state_reg == ole_pkg::S_IDLE && !req_valid, $stable(count_reg))
    `OLE_ASSERT_NEXT(a_done_loads, state_reg == ole_pkg::S_DONE && rsp_free, rsp_valid)

endmodule
